### design/qfrs_pkg.sv
// shared types and constants for the queens fitness roulette select unit
package qfrs_pkg;

  localparam int unsigned POP_MAX_DEF = 128;
  localparam int unsigned QUEENS      = 8;

  localparam logic [4:0] MAX_PAIRS      = 5'd28;
  localparam logic [7:0] POP_SIZE_RESET = 8'd100;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  typedef logic [23:0] board_t;
  typedef logic [6:0]  slot_t;
  typedef logic [4:0]  pairs_t;
  typedef logic [31:0] rand_t;
  typedef logic [7:0]  pop_size_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT,
    ST_LOAD_DONE,
    ST_SUM,
    ST_MUL,
    ST_SCAN,
    ST_FETCH,
    ST_DRAW_DONE
  } state_e;

endpackage

### design/qfrs_in_if.sv
// input channel: load or draw request word
interface qfrs_in_if;
  import qfrs_pkg::*;

  logic   valid;
  logic   ready;
  logic   mode;
  slot_t  slot;
  board_t board;
  rand_t  random_value;

  modport source (output valid, mode, slot, board, random_value, input ready);
  modport sink   (input valid, mode, slot, board, random_value, output ready);
endinterface

### design/qfrs_out_if.sv
// output channel: load acknowledge or draw report word
interface qfrs_out_if;
  import qfrs_pkg::*;

  logic   valid;
  logic   ready;
  logic   kind;
  slot_t  index;
  board_t chosen_board;
  pairs_t conflicts;
  pairs_t fitness;

  modport source (output valid, kind, index, chosen_board, conflicts, fitness, input ready);
  modport sink   (input valid, kind, index, chosen_board, conflicts, fitness, output ready);
endinterface

### design/queens_fitness_roulette_select_unit.sv
// Eight-queens fitness store with roulette wheel selection. After reset the
// block sweeps its store to zero, one slot a cycle, and accepts no word
// meanwhile. A load word counts attacking pairs one column a cycle through a
// shared compare unit, writes board and fitness into the slot if the slot
// lies below POP_MAX, and reports them. A draw word walks the store twice:
// once to total the fitness of slots 0 to size-1 and once to scan the
// running sum against R times the total (R a fraction of 2^32), with a
// multiply state between; each pass reads one slot a cycle. Input is taken
// while a finished word still waits in the output register.
module queens_fitness_roulette_select_unit #(
  parameter int unsigned POP_MAX = qfrs_pkg::POP_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  qfrs_pkg::pop_size_t   cfg_wdata_i,
  qfrs_in_if.sink               in_i,
  qfrs_out_if.source            out_o
);
  import qfrs_pkg::*;

  localparam int unsigned IW = $clog2(POP_MAX);
  localparam int unsigned SW = $clog2(POP_MAX + 1);
  localparam int unsigned CW = (SW > 8) ? SW : 8;
  localparam int unsigned TW = $clog2(28 * POP_MAX + 1);
  localparam int unsigned PW = TW + 32;
  localparam int unsigned MW = 24 + 5;

  state_e state_q, state_d;

  logic [MW-1:0] mem_q [POP_MAX];
  logic [MW-1:0] mem_rd_q;
  logic          mem_we;
  logic [IW-1:0] mem_wa, mem_ra;
  logic [MW-1:0] mem_wd;

  pop_size_t pop_q;
  logic [IW-1:0] i_q, i_d;
  logic          issue_done_q, issue_done_d;
  logic          rd_vld_q, rd_vld_d;
  logic          rd_last_q, rd_last_d;
  logic [IW-1:0] rd_addr_q, rd_addr_d;
  logic [IW-1:0] last_q, last_d;
  logic [IW-1:0] pick_q, pick_d;
  slot_t         slot_q, slot_d;
  board_t        board_q, board_d;
  rand_t         r_q, r_d;
  logic [2:0]    col_q, col_d;
  pairs_t        conf_q, conf_d;
  logic [TW-1:0] total_q, total_d;
  logic [TW-1:0] cum_q, cum_d;
  logic [PW-1:0] prod_q, prod_d;

  logic   out_vld_q, out_vld_d;
  logic   out_kind_q, out_kind_d;
  slot_t  out_index_q, out_index_d;
  board_t out_board_q, out_board_d;
  pairs_t out_conf_q, out_conf_d;
  pairs_t out_fit_q, out_fit_d;

  logic          in_acc, out_free, hit, clear_end, slot_fits;
  logic [IW-1:0] scan_lim, walk_lim;
  logic [CW-1:0] pop_ext, last_wide;
  logic [3:0]    col_hits;
  pairs_t        rd_fit;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;
  assign rd_fit     = mem_rd_q[4:0];
  assign clear_end  = (i_q == IW'(POP_MAX - 1));
  assign slot_fits  = (32'(slot_q) < 32'(POP_MAX));
  assign scan_lim   = last_q - IW'(1);
  assign walk_lim   = (state_q == ST_SCAN) ? scan_lim : last_q;
  assign cum_d      = (state_q == ST_SCAN && rd_vld_q) ? cum_q + TW'(rd_fit)
                    : (state_q == ST_SCAN) ? cum_q : '0;
  assign hit        = (total_q != '0) && ({cum_d, 32'b0} >= prod_q);

  // draw size clamped to 1..POP_MAX, kept as last slot index
  assign pop_ext   = CW'(pop_q);
  assign last_wide = (pop_q == '0) ? '0
                   : (pop_ext > CW'(POP_MAX)) ? CW'(POP_MAX - 1)
                   : pop_ext - CW'(1);

  // one column against all later columns per cycle
  always_comb begin
    logic [2:0]        ra, rb;
    logic signed [4:0] dr, dc;
    col_hits = '0;
    ra = board_q[3*col_q +: 3];
    for (int b = 0; b < QUEENS; b++) begin
      rb = board_q[3*b +: 3];
      dr = 5'(rb) - 5'(ra);
      dc = 5'(b) - 5'(col_q);
      if ((3'(b) > col_q) && (ra == rb || dc == dr || dc == -dr)) begin
        col_hits = col_hits + 4'd1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:     if (clear_end) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) state_d = (in_i.mode == MODE_LOAD) ? ST_COUNT : ST_SUM;
      end
      ST_COUNT:     if (col_q == 3'd7) state_d = ST_LOAD_DONE;
      ST_LOAD_DONE: if (out_free) state_d = ST_IDLE;
      ST_SUM:       if (rd_vld_q && rd_last_q) state_d = ST_MUL;
      ST_MUL:       state_d = (last_q == '0) ? ST_FETCH : ST_SCAN;
      ST_SCAN:      if (rd_vld_q && (hit || rd_last_q)) state_d = ST_FETCH;
      ST_FETCH:     state_d = ST_DRAW_DONE;
      ST_DRAW_DONE: if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    i_d          = i_q;
    issue_done_d = issue_done_q;
    rd_vld_d     = 1'b0;
    rd_last_d    = 1'b0;
    rd_addr_d    = i_q;
    last_d       = last_q;
    pick_d       = pick_q;
    slot_d       = slot_q;
    board_d      = board_q;
    r_d          = r_q;
    col_d        = col_q;
    conf_d       = conf_q;
    total_d      = total_q;
    prod_d       = prod_q;
    mem_we       = 1'b0;
    mem_wa       = i_q;
    mem_wd       = '0;
    mem_ra       = pick_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    out_kind_d   = out_kind_q;
    out_index_d  = out_index_q;
    out_board_d  = out_board_q;
    out_conf_d   = out_conf_q;
    out_fit_d    = out_fit_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        i_d    = clear_end ? '0 : i_q + IW'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          slot_d       = in_i.slot;
          board_d      = in_i.board;
          r_d          = in_i.random_value;
          col_d        = '0;
          conf_d       = '0;
          total_d      = '0;
          i_d          = '0;
          issue_done_d = 1'b0;
          last_d       = IW'(last_wide);
        end
      end
      ST_COUNT: begin
        conf_d = conf_q + 5'(col_hits);
        col_d  = col_q + 3'd1;
      end
      ST_LOAD_DONE: begin
        if (out_free) begin
          mem_we      = slot_fits;
          mem_wa      = IW'(slot_q);
          mem_wd      = {board_q, MAX_PAIRS - conf_q};
          out_vld_d   = 1'b1;
          out_kind_d  = MODE_LOAD;
          out_index_d = slot_q;
          out_board_d = board_q;
          out_conf_d  = conf_q;
          out_fit_d   = MAX_PAIRS - conf_q;
        end
      end
      ST_SUM, ST_SCAN: begin
        // reads go out one a cycle, data lands in the cycle after issue
        mem_ra = i_q;
        if (!issue_done_q) begin
          rd_vld_d  = 1'b1;
          rd_last_d = (i_q == walk_lim);
          if (i_q == walk_lim) issue_done_d = 1'b1;
          else                 i_d = i_q + IW'(1);
        end
        if (state_q == ST_SUM && rd_vld_q) total_d = total_q + TW'(rd_fit);
        if (state_q == ST_SCAN && rd_vld_q) begin
          if (hit)            pick_d = rd_addr_q;
          else if (rd_last_q) pick_d = last_q;
        end
      end
      ST_MUL: begin
        prod_d       = r_q * total_q;
        i_d          = '0;
        issue_done_d = 1'b0;
        pick_d       = last_q;
      end
      ST_FETCH: begin
        mem_ra = pick_q;
      end
      ST_DRAW_DONE: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_kind_d  = MODE_DRAW;
          out_index_d = 7'(pick_q);
          out_board_d = mem_rd_q[MW-1:5];
          out_conf_d  = MAX_PAIRS - rd_fit;
          out_fit_d   = rd_fit;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    mem_rd_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      pop_q        <= POP_SIZE_RESET;
      i_q          <= '0;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      rd_last_q    <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) pop_q <= cfg_wdata_i;
      i_q          <= i_d;
      issue_done_q <= issue_done_d;
      rd_vld_q     <= rd_vld_d;
      rd_last_q    <= rd_last_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q   <= rd_addr_d;
    last_q      <= last_d;
    pick_q      <= pick_d;
    slot_q      <= slot_d;
    board_q     <= board_d;
    r_q         <= r_d;
    col_q       <= col_d;
    conf_q      <= conf_d;
    total_q     <= total_d;
    cum_q       <= cum_d;
    prod_q      <= prod_d;
    out_kind_q  <= out_kind_d;
    out_index_q <= out_index_d;
    out_board_q <= out_board_d;
    out_conf_q  <= out_conf_d;
    out_fit_q   <= out_fit_d;
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.kind         = out_kind_q;
  assign out_o.index        = out_index_q;
  assign out_o.chosen_board = out_board_q;
  assign out_o.conflicts    = out_conf_q;
  assign out_o.fitness      = out_fit_q;

endmodule
